[rtl/msec_pkg.sv]
package msec_pkg;

  localparam int PROGRAM_WORDS = 4096;
  localparam int DATA_WORDS    = 1024;
  localparam int DAW           = $clog2(DATA_WORDS);
  localparam int PC_W          = 13;
  localparam int LEN_W         = 16;
  localparam int NREG          = 32;

  localparam logic [1:0] CFG_PROGRAM_LENGTH = 2'd0;
  localparam logic [1:0] CFG_DATA_LENGTH    = 2'd1;

  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_BEQ     = 6'd4;
  localparam logic [5:0] OPC_BNE     = 6'd5;
  localparam logic [5:0] OPC_ADDIU   = 6'd9;
  localparam logic [5:0] OPC_LW      = 6'd35;
  localparam logic [5:0] OPC_SW      = 6'd43;

  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_SLT     = 6'd42;

  localparam logic [31:0] SYS_PRINT = 32'd1;
  localparam logic [31:0] SYS_READ  = 32'd5;
  localparam logic [31:0] SYS_EXIT  = 32'd10;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_V0   = 5'd2;
  localparam logic [4:0] REG_A0   = 5'd4;
  localparam logic [4:0] REG_GP   = 5'd28;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_EXEC    = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_RUN    = 4'd0,
    ST_EXIT   = 4'd1,
    ST_PAST   = 4'd2,
    ST_DIVZ   = 4'd3,
    ST_TDATA  = 4'd4,
    ST_TILL   = 4'd5,
    ST_BADLD  = 4'd6,
    ST_BADST  = 4'd7,
    ST_BADENC = 4'd8
  } status_e;

  typedef enum logic [4:0] {
    OP_ADDU, OP_SUBU, OP_AND, OP_OR, OP_SLT, OP_DIV, OP_MULT, OP_MFHI, OP_MFLO,
    OP_SYSCALL, OP_ADDIU, OP_BEQ, OP_BNE, OP_J, OP_LW, OP_SW, OP_BAD,
    OP_LOADW, OP_RESTART, OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] instruction;
    logic [31:0] read_value;
    logic [9:0]  data_index;
    logic [31:0] data_value;
  } cmd_t;

endpackage

[rtl/msec_in_if.sv]
interface msec_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] instruction;
  logic signed [31:0] read_value;
  logic [9:0]  data_index;
  logic [31:0] data_value;

  modport source (output valid, func, instruction, read_value, data_index, data_value,
                  input ready);
  modport sink (input valid, func, instruction, read_value, data_index, data_value,
                output ready);
endinterface

[rtl/msec_out_if.sv]
interface msec_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] next_pc;
  logic [3:0]  status;
  logic        stopped;
  logic        print_valid;
  logic signed [31:0] print_value;

  modport source (output valid, next_pc, status, stopped, print_valid, print_value,
                  input ready);
  modport sink (input valid, next_pc, status, stopped, print_valid, print_value,
                output ready);
endinterface

[rtl/msec_cfg_if.sv]
interface msec_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/msec_ram.sv]
module msec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

[rtl/msec_front.sv]
module msec_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  msec_in_if.sink       in_i,
  output logic          cmd_valid_o,
  output msec_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import msec_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_in;

  function automatic op_e classify(logic [1:0] f, logic [31:0] w);
    op_e o;
    o = OP_BAD;
    unique case (func_e'(f))
      FUNC_LOAD:    o = OP_LOADW;
      FUNC_RESTART: o = OP_RESTART;
      FUNC_NOP:     o = OP_NOP;
      FUNC_EXEC: begin
        unique case (w[31:26])
          OPC_SPECIAL: begin
            unique case (w[5:0])
              FN_ADDU:    o = OP_ADDU;
              FN_SUBU:    o = OP_SUBU;
              FN_AND:     o = OP_AND;
              FN_OR:      o = OP_OR;
              FN_SLT:     o = OP_SLT;
              FN_DIV:     o = OP_DIV;
              FN_MULT:    o = OP_MULT;
              FN_MFHI:    o = OP_MFHI;
              FN_MFLO:    o = OP_MFLO;
              FN_SYSCALL: o = OP_SYSCALL;
              default:    o = OP_BAD;
            endcase
          end
          OPC_ADDIU: o = OP_ADDIU;
          OPC_BEQ:   o = OP_BEQ;
          OPC_BNE:   o = OP_BNE;
          OPC_J:     o = OP_J;
          OPC_LW:    o = OP_LW;
          OPC_SW:    o = OP_SW;
          default:   o = OP_BAD;
        endcase
      end
      default: o = OP_NOP;
    endcase
    return o;
  endfunction

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rptr_q];

  always_comb begin
    cmd_in.op          = classify(in_i.func, in_i.instruction);
    cmd_in.instruction = in_i.instruction;
    cmd_in.read_value  = in_i.read_value;
    cmd_in.data_index  = in_i.data_index;
    cmd_in.data_value  = in_i.data_value;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[rtl/msec_back.sv]
module msec_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  msec_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  input  logic [msec_pkg::LEN_W-1:0]  plen_i,
  input  logic [msec_pkg::LEN_W-1:0]  dlen_i,
  msec_out_if.source                  out_o
);
  import msec_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_LW, S_OUT} state_e;

  state_e      state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [31:0] hi_q, hi_d, lo_q, lo_d;
  logic        stopped_q, stopped_d;
  status_e     status_q, status_d;
  logic [NREG-1:0] rvalid_q, rvalid_d;
  logic [4:0]  ra_q, ra_d, rb_q, rb_d;
  logic        pv_q, pv_d;
  logic [31:0] pval_q, pval_d;
  logic [31:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        ovalid_q, ovalid_d;
  logic [PC_W-1:0] opc_q, opc_d;
  logic [3:0]  ost_q, ost_d;
  logic        ostop_q, ostop_d, opv_q, opv_d;
  logic [31:0] opval_q, opval_d;

  logic        rf_re, rf_we;
  logic [4:0]  rf_wa, rd_a, rd_b;
  logic [31:0] rf_wd, rdata_a, rdata_b, a, b;
  logic        dm_we, dm_re;
  logic [DAW-1:0] dm_wa, dm_ra;
  logic [31:0] dm_wd, dm_rdata;

  logic [31:0] w, sx_imm, ea, v0_new;
  logic [4:0]  rt, rd;
  logic [LEN_W:0] span;
  logic signed [17:0] br_t;
  logic        br_bad, j_bad, ea_bad, take;
  status_e     br_code, j_code;
  logic [DAW-1:0] ea_idx;
  logic [PC_W:0] pc_inc;
  logic signed [63:0] prod;
  logic [32:0] rem_sh, diff;
  logic [31:0] quo_n, rem_n;

  logic        adv_en, adv_exit, stop_en;
  logic [PC_W:0] adv_pc;
  status_e     stop_code;

  msec_ram #(.WIDTH(32), .DEPTH(NREG)) u_rf_a (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd),
    .re_i(rf_re), .raddr_i(rd_a), .rdata_o(rdata_a)
  );
  msec_ram #(.WIDTH(32), .DEPTH(NREG)) u_rf_b (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd),
    .re_i(rf_re), .raddr_i(rd_b), .rdata_o(rdata_b)
  );
  msec_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk_i, .we_i(dm_we), .waddr_i(dm_wa), .wdata_i(dm_wd),
    .re_i(dm_re), .raddr_i(dm_ra), .rdata_o(dm_rdata)
  );

  // syscall reads v0 and a0 through the two register ports
  assign rd_a = (cmd_i.op == OP_SYSCALL) ? REG_V0 : cmd_i.instruction[25:21];
  assign rd_b = (cmd_i.op == OP_SYSCALL) ? REG_A0 : cmd_i.instruction[20:16];
  assign a = rvalid_q[ra_q] ? rdata_a : 32'd0;
  assign b = rvalid_q[rb_q] ? rdata_b : 32'd0;

  assign w      = cmd_q.instruction;
  assign rt     = w[20:16];
  assign rd     = w[15:11];
  assign sx_imm = {{16{w[15]}}, w[15:0]};
  assign span   = {1'b0, plen_i} + {1'b0, dlen_i};
  assign pc_inc = {1'b0, pc_q} + 1'b1;

  assign br_t    = $signed({5'b0, pc_q}) + $signed({{2{w[15]}}, w[15:0]});
  assign br_bad  = (br_t < 0) || (br_t >= $signed({2'b0, plen_i}));
  assign br_code = ((br_t >= 0) && (br_t < $signed({1'b0, span}))) ? ST_TDATA : ST_TILL;
  assign j_bad   = w[25:0] >= 26'(plen_i);
  assign j_code  = (w[25:0] < 26'(span)) ? ST_TDATA : ST_TILL;
  assign ea      = a + sx_imm;
  assign ea_bad  = ($signed(ea) < $signed(32'(plen_i))) || ($signed(ea) >= $signed(32'(span)));
  assign ea_idx  = DAW'(ea - 32'(plen_i));
  assign take    = (a == b) == (cmd_q.op == OP_BEQ);
  assign prod    = $signed(a) * $signed(b);
  assign v0_new  = (a == SYS_READ) ? cmd_q.read_value : a;

  // one restoring divide step per cycle on magnitudes
  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign quo_n  = {quo_q[30:0], ~diff[32]};
  assign rem_n  = diff[32] ? rem_sh[31:0] : diff[31:0];

  always_comb begin
    state_d = state_q;  cmd_d = cmd_q;  pc_d = pc_q;  hi_d = hi_q;  lo_d = lo_q;
    stopped_d = stopped_q;  status_d = status_q;  rvalid_d = rvalid_q;
    ra_d = ra_q;  rb_d = rb_q;  pv_d = pv_q;  pval_d = pval_q;
    quo_d = quo_q;  rem_d = rem_q;  dvs_d = dvs_q;  qneg_d = qneg_q;  rneg_d = rneg_q;
    cnt_d = cnt_q;  ovalid_d = ovalid_q;  opc_d = opc_q;  ost_d = ost_q;
    ostop_d = ostop_q;  opv_d = opv_q;  opval_d = opval_q;
    cmd_pop_o = 1'b0;  rf_re = 1'b0;  rf_we = 1'b0;  rf_wa = REG_ZERO;  rf_wd = 32'd0;
    dm_we = 1'b0;  dm_re = 1'b0;  dm_wa = ea_idx;  dm_ra = ea_idx;  dm_wd = b;
    adv_en = 1'b0;  adv_exit = 1'b0;  adv_pc = pc_inc;
    stop_en = 1'b0;  stop_code = ST_RUN;

    if (ovalid_q && out_o.ready) ovalid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          rf_re     = 1'b1;
          cmd_d     = cmd_i;
          ra_d      = rd_a;
          rb_d      = rd_b;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        pv_d    = 1'b0;
        pval_d  = 32'd0;
        state_d = S_OUT;
        unique case (cmd_q.op)
          OP_LOADW: begin
            if (32'(cmd_q.data_index) < DATA_WORDS) begin
              dm_we = 1'b1;
              dm_wa = DAW'(cmd_q.data_index);
              dm_wd = cmd_q.data_value;
            end
          end
          OP_RESTART: begin
            rvalid_d = '0;
            rf_we = 1'b1;  rf_wa = REG_GP;  rf_wd = 32'(plen_i);
            hi_d = 32'd0;  lo_d = 32'd0;  pc_d = '0;
            stopped_d = (plen_i == '0);
            status_d  = (plen_i == '0) ? ST_PAST : ST_RUN;
          end
          OP_NOP: ;
          default: begin
            if (!stopped_q) begin
              if (LEN_W'(pc_q) >= plen_i) begin
                stop_en = 1'b1;  stop_code = ST_PAST;
              end else begin
                unique case (cmd_q.op)
                  OP_ADDU: begin rf_we = 1'b1; rf_wa = rd; rf_wd = a + b; adv_en = 1'b1; end
                  OP_SUBU: begin rf_we = 1'b1; rf_wa = rd; rf_wd = a - b; adv_en = 1'b1; end
                  OP_AND:  begin rf_we = 1'b1; rf_wa = rd; rf_wd = a & b; adv_en = 1'b1; end
                  OP_OR:   begin rf_we = 1'b1; rf_wa = rd; rf_wd = a | b; adv_en = 1'b1; end
                  OP_SLT: begin
                    rf_we = 1'b1;  rf_wa = rd;
                    rf_wd = {31'd0, $signed(a) < $signed(b)};
                    adv_en = 1'b1;
                  end
                  OP_MFHI: begin rf_we = 1'b1; rf_wa = rd; rf_wd = hi_q; adv_en = 1'b1; end
                  OP_MFLO: begin rf_we = 1'b1; rf_wa = rd; rf_wd = lo_q; adv_en = 1'b1; end
                  OP_MULT: begin
                    hi_d = prod[63:32];  lo_d = prod[31:0];  adv_en = 1'b1;
                  end
                  OP_DIV: begin
                    if (b == 32'd0) begin
                      stop_en = 1'b1;  stop_code = ST_DIVZ;
                    end else begin
                      quo_d  = a[31] ? -a : a;
                      dvs_d  = b[31] ? -b : b;
                      rem_d  = 32'd0;
                      qneg_d = a[31] ^ b[31];
                      rneg_d = a[31];
                      cnt_d  = 5'd0;
                      state_d = S_DIV;
                    end
                  end
                  OP_SYSCALL: begin
                    pv_d   = (a == SYS_PRINT);
                    pval_d = (a == SYS_PRINT) ? b : 32'd0;
                    if (a == SYS_READ) begin
                      rf_we = 1'b1;  rf_wa = REG_V0;  rf_wd = cmd_q.read_value;
                    end
                    adv_en   = 1'b1;
                    adv_exit = (v0_new == SYS_EXIT);
                  end
                  OP_ADDIU: begin
                    rf_we = 1'b1;  rf_wa = rt;  rf_wd = a + sx_imm;  adv_en = 1'b1;
                  end
                  OP_BEQ, OP_BNE: begin
                    if (take && br_bad) begin
                      stop_en = 1'b1;  stop_code = br_code;
                    end else begin
                      adv_en = 1'b1;
                      if (take) adv_pc = (PC_W + 1)'(br_t);
                    end
                  end
                  OP_J: begin
                    if (j_bad) begin
                      stop_en = 1'b1;  stop_code = j_code;
                    end else begin
                      adv_en = 1'b1;  adv_pc = (PC_W + 1)'(w[25:0]);
                    end
                  end
                  OP_LW: begin
                    if (ea_bad) begin
                      stop_en = 1'b1;  stop_code = ST_BADLD;
                    end else begin
                      dm_re = 1'b1;  state_d = S_LW;
                    end
                  end
                  OP_SW: begin
                    if (ea_bad) begin
                      stop_en = 1'b1;  stop_code = ST_BADST;
                    end else begin
                      dm_we = 1'b1;  adv_en = 1'b1;
                    end
                  end
                  default: begin
                    stop_en = 1'b1;  stop_code = ST_BADENC;
                  end
                endcase
              end
            end
          end
        endcase
      end
      S_DIV: begin
        quo_d = quo_n;
        rem_d = rem_n;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          lo_d    = qneg_q ? -quo_n : quo_n;
          hi_d    = rneg_q ? -rem_n : rem_n;
          adv_en  = 1'b1;
          state_d = S_OUT;
        end
      end
      S_LW: begin
        rf_we = 1'b1;  rf_wa = rt;  rf_wd = dm_rdata;
        adv_en  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          opc_d    = pc_q;
          ost_d    = status_q;
          ostop_d  = stopped_q;
          opv_d    = pv_q;
          opval_d  = pval_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // register zero is never written
    if (rf_wa == REG_ZERO) rf_we = 1'b0;
    if (rf_we) rvalid_d[rf_wa] = 1'b1;

    if (adv_en) begin
      pc_d = adv_pc[PC_W-1:0];
      if (adv_exit) begin
        stopped_d = 1'b1;  status_d = ST_EXIT;
      end else if (LEN_W'(adv_pc) >= plen_i) begin
        stopped_d = 1'b1;  status_d = ST_PAST;
      end
    end
    if (stop_en) begin
      stopped_d = 1'b1;
      status_d  = stop_code;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;   ra_q   <= ra_d;    rb_q   <= rb_d;
    pv_q   <= pv_d;    pval_q <= pval_d;
    quo_q  <= quo_d;   rem_q  <= rem_d;   dvs_q  <= dvs_d;
    qneg_q <= qneg_d;  rneg_q <= rneg_d;  cnt_q  <= cnt_d;
    opc_q  <= opc_d;   ost_q  <= ost_d;   ostop_q <= ostop_d;
    opv_q  <= opv_d;   opval_q <= opval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= '0;
      hi_q      <= 32'd0;
      lo_q      <= 32'd0;
      stopped_q <= 1'b0;
      status_q  <= ST_RUN;
      rvalid_q  <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      stopped_q <= stopped_d;
      status_q  <= status_d;
      rvalid_q  <= rvalid_d;
      ovalid_q  <= ovalid_d;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.next_pc     = opc_q;
  assign out_o.status      = ost_q;
  assign out_o.stopped     = ostop_q;
  assign out_o.print_valid = opv_q;
  assign out_o.print_value = opval_q;
endmodule

[rtl/mips_subset_execute_core.sv]
// channel | dir | handshake     | payload
// cfg_i   | in  | valid / ready | index, data (program_length, data_length)
// in_i    | in  | valid / ready | func, instruction, read_value, data_index, data_value
// out_o   | out | valid / ready | next_pc, status, stopped, print_valid, print_value
//
// items sit in a two-entry queue; the executor takes one at a time
// simple items pass register file read, execute and output register stages,
// lw adds a data memory read, div adds a divide loop (one quotient bit per cycle)
// reset clears registers, hi, lo, pc and the run state; data memory is not cleared
// a stalled output holds the executor, which in turn fills the queue
module mips_subset_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  msec_cfg_if.sink    cfg_i,
  msec_in_if.sink     in_i,
  msec_out_if.source  out_o
);
  import msec_pkg::*;

  logic [12:0]      prog_len_q;
  logic [10:0]      data_len_q;
  logic [LEN_W-1:0] plen, dlen;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= 13'd1;
      data_len_q <= 11'd0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_PROGRAM_LENGTH) prog_len_q <= cfg_i.data;
      if (cfg_i.index == CFG_DATA_LENGTH)    data_len_q <= cfg_i.data[10:0];
    end
  end

  assign plen = (32'(prog_len_q) < PROGRAM_WORDS) ? LEN_W'(prog_len_q) : LEN_W'(PROGRAM_WORDS);
  assign dlen = (32'(data_len_q) < DATA_WORDS) ? LEN_W'(data_len_q) : LEN_W'(DATA_WORDS);

  msec_front u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  msec_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .plen_i(plen), .dlen_i(dlen), .out_o
  );
endmodule
